// ----- rtl/sale_pkg.sv -----
// Shared constants, command and status codes, and the check result type
// of the sorted array list engine. No dependencies.
`default_nettype none

package sale_pkg;

   // Geometry of the list storage.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the command and response beats.
   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;

   // Width used to compare a position against the fill level.
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_AT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SORTED = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd6;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // Outcome of the command check: the status, and whether the command
   // goes on to touch the list.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              go;
   } chk_type;

endpackage

`default_nettype wire

// ----- rtl/sale_check.sv -----
// Command check of the sorted array list engine: full list and position
// range tests against the current fill level. Depends on sale_pkg.
`default_nettype none

module sale_check (
   input  wire logic [sale_pkg::CMD_W-1:0] command,
   input  wire logic [sale_pkg::POS_W-1:0] position,
   input  wire logic [sale_pkg::LEN_W-1:0] length,
   output sale_pkg::chk_type               chk
);
   import sale_pkg::*;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] len_ext;
   logic             full;

   assign pos_ext = CMP_W'(position);
   assign len_ext = CMP_W'(length);
   assign full    = (length >= LEN_W'(CAPACITY));

   always_comb begin
      chk.status = STAT_OK;
      chk.go     = 1'b1;
      case (command)
         CMD_CLEAR: begin
            chk.go = 1'b1;
         end
         CMD_APPEND, CMD_SORTED: begin
            if (full) begin
               chk.status = STAT_FULL;
               chk.go     = 1'b0;
            end
         end
         CMD_INS_AT: begin
            // The full test takes precedence over the position test.
            if (full) begin
               chk.status = STAT_FULL;
               chk.go     = 1'b0;
            end else if (pos_ext > len_ext) begin
               chk.status = STAT_RANGE;
               chk.go     = 1'b0;
            end
         end
         CMD_REMOVE, CMD_READ, CMD_WRITE: begin
            if (pos_ext >= len_ext) begin
               chk.status = STAT_RANGE;
               chk.go     = 1'b0;
            end
         end
         default: begin
            chk.go = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/sorted_array_list_engine_core.sv -----
// Top level of the sorted array list engine: command sequencer around a
// single list memory. Depends on sale_pkg and sale_check.
`default_nettype none

// Channel     Ports                                              Handshake
// command     req_command, req_position, req_value               start / busy
// response    rsp_status, rsp_data_out, rsp_slot_used, rsp_count rsp_valid strobe
//
// Clear, append, write_at, error cases and the unused command answer from
// idle, as do an insert at the end of the list and a sorted insert into an
// empty list. Read_at passes through the first-read state. Remove_at, any
// other insert_at and a sorted insert into a non-empty list walk the list
// memory one entry per cycle through its single read port and single write
// port. Reset clears the sequencer, the fill level and the response strobe;
// the list contents are undefined until written. The response is a one-cycle
// strobe that the receiver cannot stall, and a new command may start in the
// same cycle that the previous response is shown.

module sorted_array_list_engine_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [sale_pkg::CMD_W-1:0]   req_command,
   input  wire logic        [sale_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [sale_pkg::DATA_W-1:0]  req_value,
   output logic                                     rsp_valid,
   output logic             [sale_pkg::STAT_W-1:0]  rsp_status,
   output logic signed      [sale_pkg::DATA_W-1:0]  rsp_data_out,
   output logic             [sale_pkg::POS_W-1:0]   rsp_slot_used,
   output logic             [sale_pkg::CNT_W-1:0]   rsp_count
);
   import sale_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command
   localparam logic [2:0] S_FIRST = 3'd1;  // read data of the target slot arrives
   localparam logic [2:0] S_DOWN  = 3'd2;  // remove: shift entries down by one
   localparam logic [2:0] S_UP    = 3'd3;  // insert: search and ripple entries up
   localparam logic [2:0] S_TAIL  = 3'd4;  // insert: write the last carried word

   // List storage: one write port and one registered read port.
   logic signed [DATA_W-1:0] entry_ram_ff [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic                     mem_re;
   logic [IDX_W-1:0]         mem_raddr;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;

   // Per-command working registers.
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0]         idx_ff, idx_in;
   logic [LEN_W-1:0]         slot_ff, slot_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     found_ff, found_in;

   // Response registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   // Helpers.
   chk_type          chk;
   logic [LEN_W-1:0] pos_len;
   logic [LEN_W-1:0] start_idx;
   logic [LEN_W-1:0] idx_nxt;
   logic [LEN_W-1:0] idx_prv;
   logic [LEN_W-1:0] len_inc;
   logic [LEN_W-1:0] len_dec;
   logic             greater;

   sale_check u_check (
      .command  (req_command),
      .position (req_position),
      .length   (length_ff),
      .chk      (chk)
   );

   // A position that passed the check is no larger than the fill level,
   // so it fits the length width.
   assign pos_len   = LEN_W'(req_position);
   assign start_idx = (req_command == CMD_SORTED) ? '0 : pos_len;
   assign idx_nxt   = idx_ff + LEN_W'(1);
   assign idx_prv   = idx_ff - LEN_W'(1);
   assign len_inc   = length_ff + LEN_W'(1);
   assign len_dec   = length_ff - LEN_W'(1);
   assign greater   = (rd_data_ff > val_ff);

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_slot_used = rsp_slot_ff;
   assign rsp_count     = rsp_count_ff;

   // Sequencer. Every walk reads one slot and writes a different slot in
   // the same cycle (the slot below on the way down, the slot just read
   // on the way up), so a read never meets a write to the same entry and
   // no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      carry_in      = carry_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               val_in  = req_value;
               slot_in = start_idx;
               if (!chk.go) begin
                  // Errors and the unused command leave the list alone.
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = chk.status;
                  rsp_data_in   = '0;
                  rsp_slot_in   = '0;
                  rsp_count_in  = CNT_W'(length_ff);
               end else begin
                  case (req_command)
                     CMD_CLEAR: begin
                        length_in     = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_data_in   = '0;
                        rsp_slot_in   = '0;
                        rsp_count_in  = '0;
                     end
                     CMD_APPEND: begin
                        mem_we        = 1'b1;
                        mem_waddr     = length_ff[IDX_W-1:0];
                        mem_wdata     = req_value;
                        length_in     = len_inc;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_data_in   = '0;
                        rsp_slot_in   = POS_W'(length_ff);
                        rsp_count_in  = CNT_W'(len_inc);
                     end
                     CMD_WRITE: begin
                        mem_we        = 1'b1;
                        mem_waddr     = pos_len[IDX_W-1:0];
                        mem_wdata     = req_value;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_data_in   = '0;
                        rsp_slot_in   = req_position;
                        rsp_count_in  = CNT_W'(length_ff);
                     end
                     CMD_READ, CMD_REMOVE: begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_len[IDX_W-1:0];
                        idx_in    = pos_len;
                        state_in  = S_FIRST;
                     end
                     CMD_INS_AT, CMD_SORTED: begin
                        if (start_idx == length_ff) begin
                           // Nothing above the slot: place the word directly.
                           mem_we        = 1'b1;
                           mem_waddr     = start_idx[IDX_W-1:0];
                           mem_wdata     = req_value;
                           length_in     = len_inc;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = STAT_OK;
                           rsp_data_in   = '0;
                           rsp_slot_in   = POS_W'(start_idx);
                           rsp_count_in  = CNT_W'(len_inc);
                        end else begin
                           // A positioned insert has its slot already; a sorted
                           // insert still searches for the first larger entry.
                           mem_re    = 1'b1;
                           mem_raddr = start_idx[IDX_W-1:0];
                           idx_in    = start_idx;
                           carry_in  = req_value;
                           found_in  = (req_command == CMD_INS_AT);
                           state_in  = S_UP;
                        end
                     end
                     default: begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_data_in   = '0;
                        rsp_slot_in   = '0;
                        rsp_count_in  = CNT_W'(length_ff);
                     end
                  endcase
               end
            end
         end

         S_FIRST: begin
            data_in = rd_data_ff;
            if (cmd_ff == CMD_READ) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = rd_data_ff;
               rsp_slot_in   = POS_W'(idx_ff);
               rsp_count_in  = CNT_W'(length_ff);
               state_in      = S_IDLE;
            end else if (idx_nxt == length_ff) begin
               // Removing the last entry needs no shift.
               length_in     = len_dec;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = rd_data_ff;
               rsp_slot_in   = POS_W'(idx_ff);
               rsp_count_in  = CNT_W'(len_dec);
               state_in      = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_nxt[IDX_W-1:0];
               idx_in    = idx_nxt;
               state_in  = S_DOWN;
            end
         end

         S_DOWN: begin
            // The entry read last cycle moves one slot down.
            mem_we    = 1'b1;
            mem_waddr = idx_prv[IDX_W-1:0];
            mem_wdata = rd_data_ff;
            if (idx_nxt == length_ff) begin
               length_in     = len_dec;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = data_ff;
               rsp_slot_in   = POS_W'(slot_ff);
               rsp_count_in  = CNT_W'(len_dec);
               state_in      = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_nxt[IDX_W-1:0];
               idx_in    = idx_nxt;
            end
         end

         S_UP: begin
            // Once the slot is known, each entry is replaced by the word
            // carried from below and its old value is carried on upward.
            if (found_ff || greater) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff[IDX_W-1:0];
               mem_wdata = carry_ff;
               carry_in  = rd_data_ff;
               if (!found_ff) begin
                  found_in = 1'b1;
                  slot_in  = idx_ff;
               end
            end
            idx_in = idx_nxt;
            if (idx_nxt == length_ff) begin
               state_in = S_TAIL;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_nxt[IDX_W-1:0];
            end
         end

         S_TAIL: begin
            // The carried word lands in the new top slot. If the search found
            // no larger entry, the carried word is the new value itself.
            mem_we        = 1'b1;
            mem_waddr     = length_ff[IDX_W-1:0];
            mem_wdata     = carry_ff;
            length_in     = len_inc;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_data_in   = '0;
            rsp_slot_in   = found_ff ? POS_W'(slot_ff) : POS_W'(length_ff);
            rsp_count_in  = CNT_W'(len_inc);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      carry_ff      <= carry_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // List memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ram_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= entry_ram_ff[mem_raddr];
      end
   end

endmodule

`default_nettype wire

// ----- sim/sorted_array_list_engine_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of sorted_array_list_engine_core: it drives list commands,
// keeps its own copy of the list to predict each response, and checks every response strobe.
// Depends on sale_pkg and the engine RTL.

module sorted_array_list_engine_core_test;
   import sale_pkg::*;

   // Command code 7 has no name in the package. The engine must answer it
   // with an ok status and leave the list alone.
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

   localparam int RANDOM_BEATS = 500;
   // The last stretch of commands goes out back to back, with no idling.
   localparam int CALM_TAIL    = 40;
   // The limit leaves ample margin for about 525 commands, even with every
   // command at its slowest and the longest idle bursts.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   // One response beat, as the list should report it.
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] data_out;
      logic [POS_W-1:0]         slot_used;
      logic [CNT_W-1:0]         count;
   } list_reply_type;

   // Scoreboard: a shadow copy of the list, plus the responses that the
   // engine still owes, oldest first.
   class list_scoreboard;
      logic signed [DATA_W-1:0] slots [CAPACITY];
      int                       fill;
      list_reply_type           awaited_replies [$];
      int                       fails;

      function new();
         fill  = 0;
         fails = 0;
      endfunction

      // Apply one accepted command to the shadow list and queue the
      // response it must produce.
      function void apply_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                  logic signed [DATA_W-1:0] word);
         list_reply_type r;
         int             i;
         int             at;
         r = '0;
         case (op)
            CMD_CLEAR: begin
               fill = 0;
            end
            CMD_APPEND, CMD_INS_AT, CMD_SORTED: begin
               // A full list wins over a bad position.
               if (fill >= CAPACITY) begin
                  r.status = STAT_FULL;
               end else begin
                  at = fill;
                  if (op == CMD_INS_AT) begin
                     at = (int'(pos) > fill) ? -1 : int'(pos);
                  end else if (op == CMD_SORTED) begin
                     // The new word goes before the first entry that is
                     // strictly greater, so equal words keep their order.
                     at = 0;
                     while (at < fill && slots[at] <= word) at++;
                  end
                  if (at < 0) begin
                     r.status = STAT_RANGE;
                  end else begin
                     for (i = fill; i > at; i--) slots[i] = slots[i-1];
                     slots[at]   = word;
                     fill++;
                     r.slot_used = POS_W'(at);
                  end
               end
            end
            CMD_REMOVE, CMD_READ, CMD_WRITE: begin
               if (int'(pos) >= fill) begin
                  r.status = STAT_RANGE;
               end else begin
                  r.slot_used = pos;
                  if (op == CMD_WRITE) begin
                     slots[pos] = word;
                  end else begin
                     r.data_out = slots[pos];
                  end
                  if (op == CMD_REMOVE) begin
                     for (i = int'(pos); i + 1 < fill; i++) slots[i] = slots[i+1];
                     fill--;
                  end
               end
            end
            default: begin
            end
         endcase
         r.count = CNT_W'(fill);
         awaited_replies.push_back(r);
      endfunction

      // Compare one response beat with the oldest response still owed.
      function void match_reply(list_reply_type got);
         list_reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("response with none outstanding: status %0d data_out %0d slot %0d count %0d",
                   got.status, got.data_out, got.slot_used, got.count);
            fails++;
            return;
         end
         want = awaited_replies.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
         end
         if (got.data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
            fails++;
         end
         if (got.slot_used !== want.slot_used) begin
            $error("slot_used: expected %0d, got %0d", want.slot_used, got.slot_used);
            fails++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fails++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [CMD_W-1:0]         req_command  = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic                     rsp_valid;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [POS_W-1:0]         rsp_slot_used;
   logic [CNT_W-1:0]         rsp_count;

   list_scoreboard board = new();
   int             cycles = 0;

   sorted_array_list_engine_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_slot_used (rsp_slot_used),
      .rsp_count     (rsp_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("sorted_array_list_engine_core_test: errors");
         $finish;
      end
   end

   // The response is a one-cycle strobe. It is sampled at the edge that ends
   // its cycle, so the values seen here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.match_reply({rsp_status, rsp_data_out, rsp_slot_used, rsp_count});
      end
   end

   // Drive one command beat and hold it until the engine takes it. The beat
   // is taken at an edge where start is high and busy was low. The shadow
   // list is updated right here, so the next command can be chosen from the
   // list as it now stands. The task returns at that same edge, which lets a
   // following beat go out with start held high and no gap.
   task automatic send_beat(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] word);
      start        <= 1'b1;
      req_command  <= op;
      req_position <= pos;
      req_value    <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.apply_command(op, pos, word);
   endtask

   // Idle burst: start drops and the payload carries junk, which the engine
   // must ignore.
   task automatic idle_burst(int n);
      start        <= 1'b0;
      req_command  <= CMD_W'($urandom);
      req_position <= POS_W'($urandom);
      req_value    <= $urandom;
      repeat (n) @(posedge clock);
   endtask

   // Position for the next command: mostly a valid slot for the list as it
   // stands (up to the fill level for inserts), sometimes anything at all.
   function automatic logic [POS_W-1:0] aim_slot(bit for_insert);
      int top;
      top = for_insert ? board.fill : board.fill - 1;
      if (top < 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
      return POS_W'($urandom_range(0, top));
   endfunction

   // Word to store: small values give many duplicates for the sorted insert,
   // and the signed extremes turn up now and then.
   function automatic logic signed [DATA_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return int'($urandom_range(0, 8)) - 4;
      if (r == 3) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return $urandom;
   endfunction

   // Command mix of each kind of stretch: growing fills the list up to the
   // full case, shrinking empties it, the sorted stretch builds an ordered
   // list, and the mixed one takes any code, the unused one among them.
   function automatic logic [CMD_W-1:0] pick_command(int mode);
      int r;
      logic [CMD_W-1:0] op;
      r = $urandom_range(0, 99);
      case (mode)
         0: op = (r < 25) ? CMD_APPEND : (r < 55) ? CMD_INS_AT : (r < 85) ? CMD_SORTED :
                 (r < 90) ? CMD_READ : (r < 95) ? CMD_WRITE : CMD_REMOVE;
         1: op = (r < 45) ? CMD_REMOVE : (r < 65) ? CMD_READ : (r < 80) ? CMD_WRITE :
                 (r < 90) ? CMD_INS_AT : CMD_APPEND;
         2: op = (r < 60) ? CMD_SORTED : (r < 75) ? CMD_READ : (r < 90) ? CMD_REMOVE :
                 CMD_WRITE;
         default: begin
            op = CMD_W'($urandom_range(0, 7));
            // Keep clears rare, or the list would never get deep.
            if (op == CMD_CLEAR && r < 75) op = CMD_READ;
         end
      endcase
      return op;
   endfunction

   initial begin
      int          mode;
      int          run_len;
      bit          gaps_on;
      int          k;
      logic [CMD_W-1:0] op;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the empty list every access is out of range, an
      // insert past the end is out of range, and the unused code is a no-op.
      send_beat(CMD_READ, 5'd0, 32'sd0);
      send_beat(CMD_REMOVE, 5'd0, 32'sd0);
      send_beat(CMD_WRITE, 5'd0, 32'sd9);
      send_beat(CMD_INS_AT, 5'd1, 32'sd9);
      send_beat(CMD_SPARE, 5'd31, 32'sh7FFF_FFFF);
      send_beat(CMD_CLEAR, 5'd31, 32'sh8000_0000);
      // Signed extremes, then sorted inserts around them, including values
      // equal to ones already stored.
      send_beat(CMD_APPEND, 5'd0, 32'sh7FFF_FFFF);
      send_beat(CMD_APPEND, 5'd31, 32'sh8000_0000);
      send_beat(CMD_SORTED, 5'd0, 32'sd0);
      send_beat(CMD_INS_AT, 5'd0, -32'sd1);
      send_beat(CMD_INS_AT, POS_W'(board.fill), 32'sd5);
      send_beat(CMD_SORTED, 5'd0, 32'sh7FFF_FFFF);
      send_beat(CMD_SORTED, 5'd0, 32'sh8000_0000);
      // Accesses at the edges of the valid range and just past it.
      send_beat(CMD_READ, 5'd31, 32'sd0);
      send_beat(CMD_READ, POS_W'(board.fill - 1), 32'sd0);
      send_beat(CMD_WRITE, 5'd0, 32'sh1234_5678);
      send_beat(CMD_REMOVE, 5'd0, 32'sd0);
      send_beat(CMD_REMOVE, POS_W'(board.fill - 1), 32'sd0);
      send_beat(CMD_REMOVE, POS_W'(board.fill), 32'sd0);
      send_beat(CMD_INS_AT, POS_W'(board.fill + 1), 32'sd7);
      send_beat(CMD_INS_AT, 5'd31, 32'sd7);
      send_beat(CMD_CLEAR, 5'd0, 32'sd0);

      // Random part, in stretches of one kind each. The first stretch always
      // grows, so the full-list case comes early, and the fill level is the
      // shadow list's own, so positions track the real contents.
      k = 0;
      while (k < RANDOM_BEATS) begin
         mode    = (k == 0) ? 0 : $urandom_range(0, 3);
         run_len = (k == 0) ? 30 : $urandom_range(8, 40);
         gaps_on = $urandom_range(0, 1);
         if (mode == 2) begin
            send_beat(CMD_CLEAR, aim_slot(1'b0), pick_word());
            k++;
         end
         repeat (run_len) begin
            if (k < RANDOM_BEATS) begin
               op = pick_command(mode);
               send_beat(op, aim_slot(op == CMD_INS_AT), pick_word());
               k++;
               if (gaps_on && k < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
                  idle_burst($urandom_range(1, 14));
               end
            end
         end
      end

      // Drain: wait for every owed response, then a few more cycles so that
      // a stray strobe would still be caught.
      start <= 1'b0;
      while (board.awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fails == 0) begin
         $display("sorted_array_list_engine_core_test: clean");
      end else begin
         $display("sorted_array_list_engine_core_test: errors");
      end
      $finish;
   end

endmodule
